// File: rtl/vtae_pkg.sv
// Shared types and constants for the vector terminal address encoder.
package vtae_pkg;

    typedef enum logic [2:0] {
        OP_MOVE  = 3'd0,
        OP_DRAW  = 3'd1,
        OP_PLOT  = 3'd2,
        OP_ALPHA = 3'd3,
        OP_CLEAR = 3'd4
    } op_e_t;

    localparam int unsigned SLOTS = 5;

    localparam logic [9:0] X_MAX = 10'd1023;
    localparam logic [9:0] Y_MAX = 10'd767;

    localparam logic [6:0] CH_GS    = 7'o035;
    localparam logic [6:0] CH_US    = 7'o037;
    localparam logic [6:0] CH_ESC   = 7'o033;
    localparam logic [6:0] CH_FF    = 7'o014;
    localparam logic [6:0] CH_AT    = 7'o100;
    localparam logic [6:0] TAG_HIGH = 7'o040;
    localparam logic [6:0] TAG_LOWY = 7'o140;
    localparam logic [6:0] TAG_LOWX = 7'o100;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] out_byte;
        logic       last_byte;
    } out_beat_t;

    // One classified command: byte slots in send order, mask of those to send.
    typedef struct packed {
        logic [SLOTS-1:0][6:0] bytes;
        logic [SLOTS-1:0]      mask;
    } job_t;

endpackage

// File: rtl/vtae_front.sv
// Front end: accepts commands, clamps and splits coordinates, filters repeats.
module vtae_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vtae_pkg::in_beat_t in_data,
    input  logic              q_full,
    output logic              push,
    output vtae_pkg::job_t    push_job
);

    logic [6:0] prev_high_y_reg, prev_high_y_next;
    logic [6:0] prev_low_y_reg,  prev_low_y_next;
    logic [6:0] prev_high_x_reg, prev_high_x_next;

    logic       accept;
    logic [9:0] x_clamp;
    logic [9:0] y_clamp;
    logic [6:0] hy, ly, hx, lx;
    logic       hx_diff;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (in_data.x_coord[15])
            x_clamp = 10'd0;
        else if (in_data.x_coord[14:0] > {5'd0, vtae_pkg::X_MAX})
            x_clamp = vtae_pkg::X_MAX;
        else
            x_clamp = in_data.x_coord[9:0];

        if (in_data.y_coord[15])
            y_clamp = 10'd0;
        else if (in_data.y_coord[14:0] > {5'd0, vtae_pkg::Y_MAX})
            y_clamp = vtae_pkg::Y_MAX;
        else
            y_clamp = in_data.y_coord[9:0];
    end

    assign hy = vtae_pkg::TAG_HIGH | {2'b00, y_clamp[9:5]};
    assign ly = vtae_pkg::TAG_LOWY | {2'b00, y_clamp[4:0]};
    assign hx = vtae_pkg::TAG_HIGH | {2'b00, x_clamp[9:5]};
    assign lx = vtae_pkg::TAG_LOWX | {2'b00, x_clamp[4:0]};
    assign hx_diff = (hx != prev_high_x_reg);

    always_comb
    begin
        push_job         = '0;
        prev_high_y_next = prev_high_y_reg;
        prev_low_y_next  = prev_low_y_reg;
        prev_high_x_next = prev_high_x_reg;
        unique case (in_data.op) inside
            vtae_pkg::OP_MOVE, vtae_pkg::OP_DRAW:
            begin
                push_job.bytes = {lx, hx, ly, hy, vtae_pkg::CH_GS};
                push_job.mask  = {1'b1, hx_diff, (ly != prev_low_y_reg) || hx_diff,
                                  hy != prev_high_y_reg, in_data.op == vtae_pkg::OP_MOVE};
                prev_high_y_next = hy;
                prev_low_y_next  = ly;
                prev_high_x_next = hx;
            end
            vtae_pkg::OP_PLOT:
            begin
                push_job.bytes[0] = vtae_pkg::CH_GS;
                push_job.bytes[1] = vtae_pkg::CH_AT;
                push_job.mask     = 5'b00011;
                prev_high_y_next  = '0;
                prev_low_y_next   = '0;
                prev_high_x_next  = '0;
            end
            vtae_pkg::OP_ALPHA:
            begin
                push_job.bytes[0] = vtae_pkg::CH_US;
                push_job.mask     = 5'b00001;
            end
            vtae_pkg::OP_CLEAR:
            begin
                push_job.bytes[0] = vtae_pkg::CH_ESC;
                push_job.bytes[1] = vtae_pkg::CH_FF;
                push_job.mask     = 5'b00011;
            end
            default:
            begin
                push_job = '0;  // undefined op: nothing sent, state kept
            end
        endcase
    end

    assign push = accept && (push_job.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_high_y_reg <= '0;
            prev_low_y_reg  <= '0;
            prev_high_x_reg <= '0;
        end
        else if (accept)
        begin
            prev_high_y_reg <= prev_high_y_next;
            prev_low_y_reg  <= prev_low_y_next;
            prev_high_x_reg <= prev_high_x_next;
        end
    end

    a_plot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.op == vtae_pkg::OP_PLOT |=>
        prev_high_y_reg == '0 && prev_low_y_reg == '0 && prev_high_x_reg == '0)
        else $error("plot mode did not clear remembered bytes");

    a_drop_only_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_data.op == vtae_pkg::OP_MOVE || in_data.op == vtae_pkg::OP_DRAW)
        |-> push)
        else $error("move or draw produced no job");

    a_lowx_always: assert property (@(posedge clk) disable iff (!rst_n)
        push && (in_data.op == vtae_pkg::OP_MOVE || in_data.op == vtae_pkg::OP_DRAW)
        |-> push_job.mask[4])
        else $error("low-X byte missing from move or draw");

endmodule

// File: rtl/vtae_queue.sv
// Small job queue between front end and byte sequencer.
module vtae_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vtae_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output vtae_pkg::job_t q_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    vtae_pkg::job_t entries [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// File: rtl/vtae_back.sv
// Byte sequencer: walks a job's send mask, one byte per cycle into the output register while that register is free.
module vtae_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  vtae_pkg::job_t      q_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output vtae_pkg::out_beat_t out_data
);

    vtae_pkg::job_t      job_reg,       job_next;
    logic                busy_reg,      busy_next;
    logic                out_valid_reg, out_valid_next;
    vtae_pkg::out_beat_t out_data_reg,  out_data_next;

    logic [2:0]                    sel;
    logic [vtae_pkg::SLOTS-1:0]    sel_hot;
    logic [vtae_pkg::SLOTS-1:0]    rest;
    logic                          slot_free;
    logic                          emit;
    logic                          final_byte;

    // lowest pending slot goes next
    always_comb
    begin
        sel = '0;
        for (int i = vtae_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (job_reg.mask[i])
                sel = 3'(i);
        end
    end

    assign sel_hot    = vtae_pkg::SLOTS'(1) << sel;
    assign rest       = job_reg.mask & ~sel_hot;
    assign slot_free  = !out_valid_reg || out_ready;
    assign emit       = busy_reg && slot_free;
    assign final_byte = (rest == '0);
    assign pop        = q_valid && (!busy_reg || (emit && final_byte));

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            job_next  = q_job;
            busy_next = 1'b1;
        end
        else if (emit)
        begin
            job_next.mask = rest;
            busy_next     = !final_byte;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.out_byte  = job_reg.bytes[sel];
            out_data_next.last_byte = final_byte;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> job_reg.mask != '0)
        else $error("sequencer busy with empty mask");

    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !busy_reg || final_byte)
        else $error("new job loaded over unfinished one");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted byte lost");

endmodule

// File: rtl/vector_terminal_address_encoder_top.sv
// Top level of the vector terminal address encoder.
//
//  channel | dir | handshake              | beat
//  --------+-----+------------------------+------------------------------------
//  in      | in  | in_valid / in_ready    | in_beat_t  {op, x_coord, y_coord}
//  out     | out | out_valid / out_ready  | out_beat_t {out_byte, last_byte}
//
// Cycles: one output byte per cycle while the output register is free; a command
// sends 1 to 5 bytes, all through the single-byte output register in the sequencer.
// Commands are taken back to back while the job queue has room; an undefined
// op is taken and sends nothing.
// Reset: clears the queue, the sequencer and the remembered Y/X bytes.
// Stalls: out_ready low holds the output register; the front keeps accepting
// until the queue (QUEUE_DEPTH jobs) fills.
module vector_terminal_address_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vtae_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vtae_pkg::out_beat_t out_data
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    vtae_pkg::job_t push_job;
    vtae_pkg::job_t q_job;

    // front: clamp, split, drop repeated bytes, track remembered bytes
    vtae_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // decouples command intake from byte output
    vtae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // back: serializes each job's selected bytes, tags the final one
    vtae_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
